// ===== hdl/absf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// absf_pkg: shared constants and types for the blended square fill block
// Frame geometry, field widths, blend arithmetic constants and the structs
// that pass between the sequencer, the blend pipeline and the frame memory.
// -----------------------------------------------------------------------------
package absf_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Field widths
  localparam int OP_W      = 2;
  localparam int COORD_W   = 8;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int PIX_W     = NUM_CH * CH_W;
  localparam int ALPHA_W   = 7;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  // Width that holds a clipped bound, an active size and center plus radius
  localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W   = $clog2(DIM_MAX + 1);
  localparam int SPAN_W  = COORD_W + 1;
  localparam int EXT_A   = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  localparam int EXT_W   = (EXT_A > SPAN_W) ? EXT_A : SPAN_W;

  // Blend arithmetic: each channel is (old*(100-a) + new*a) / 100
  localparam int ALPHA_FULL = 100;
  localparam int ACC_W      = CH_W + ALPHA_W;
  localparam int DIV_SHIFT  = 21;
  localparam int DIV_RECIP  = ((1 << DIV_SHIFT) + ALPHA_FULL - 1) / ALPHA_FULL;
  localparam int RECIP_W    = $clog2(DIV_RECIP + 1);
  localparam int DIV_PROD_W = ACC_W + RECIP_W;

  // Register reset values
  localparam logic [CFG_W-1:0] ACT_WIDTH_RST  = CFG_W'(256);
  localparam logic [CFG_W-1:0] ACT_HEIGHT_RST = CFG_W'(256);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_WIDTH  = 1'b0,
    CFG_ACTIVE_HEIGHT = 1'b1
  } cfg_e;

  // Channel 2 is red, 1 green, 0 blue
  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] radius;
    pixel_t             color;
    logic [ALPHA_W-1:0] alpha;
  } item_t;

  typedef struct packed {
    logic              en;
    logic              mix;   // read feeds the blend pipeline
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    pixel_t            data;
  } wr_req_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]            inv;
    logic [NUM_CH-1:0][ACC_W-1:0]  scaled;
  } coef_t;

endpackage
`default_nettype wire

// ===== hdl/absf_frame_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// absf_frame_ram: frame store memory
// One write port and one read port, read data registered.
// -----------------------------------------------------------------------------
module absf_frame_ram (
  input  wire logic              clk_i,
  input  wire absf_pkg::wr_req_t wr_i,
  input  wire absf_pkg::rd_req_t rd_i,
  output absf_pkg::pixel_t       rd_data_o
);
  import absf_pkg::*;

  pixel_t frame_mem [DEPTH];
  pixel_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      frame_mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= frame_mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ===== hdl/absf_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// absf_blend: two-stage read-modify-write blend pipeline
// Stage one forms old*(100-a) + new*a per channel, stage two divides by 100
// through a reciprocal multiply and writes the pixel back.
// -----------------------------------------------------------------------------
module absf_blend (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire absf_pkg::rd_req_t rd_i,
  input  wire absf_pkg::pixel_t  rd_data_i,
  input  wire absf_pkg::coef_t   coef_i,
  output absf_pkg::wr_req_t      wr_o,
  output logic                   busy_o
);
  import absf_pkg::*;

  localparam int SUM_W = ACC_W + 1;

  logic                          v1_q, v2_q;
  logic [ADDR_W-1:0]             a1_q, a2_q;
  logic [NUM_CH-1:0][ACC_W-1:0]  acc_d, acc_q;
  pixel_t                        mix_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= rd_i.en & rd_i.mix;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q  <= rd_i.addr;
    a2_q  <= a1_q;
    acc_q <= acc_d;
  end

  // Stage one: weighted sum, bounded by 255*100
  always_comb begin
    logic [ACC_W-1:0] prod;
    logic [SUM_W-1:0] sum;
    acc_d = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      prod     = ACC_W'(rd_data_i[c]) * ACC_W'(coef_i.inv);
      sum      = SUM_W'(prod) + SUM_W'(coef_i.scaled[c]);
      acc_d[c] = sum[ACC_W-1:0];
    end
  end

  // Stage two: divide by 100 as multiply by reciprocal and shift
  always_comb begin
    logic [DIV_PROD_W-1:0] prod;
    mix_pix = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      prod       = DIV_PROD_W'(acc_q[c]) * DIV_PROD_W'(DIV_RECIP);
      mix_pix[c] = prod[DIV_SHIFT +: CH_W];
    end
  end

  assign wr_o.en   = v2_q;
  assign wr_o.addr = a2_q;
  assign wr_o.data = mix_pix;
  assign busy_o    = v1_q | v2_q;

endmodule
`default_nettype wire

// ===== hdl/absf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// absf_ctrl: operation sequencer
// Clips the square, walks its pixels one per cycle, sweeps the store on a
// clear, issues pixel reads and hands one result per item to the output.
// -----------------------------------------------------------------------------
module absf_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire absf_pkg::item_t                 item_i,
  input  wire logic [absf_pkg::CFG_W-1:0]      act_width_i,
  input  wire logic [absf_pkg::CFG_W-1:0]      act_height_i,
  output absf_pkg::rd_req_t                    rd_o,
  output absf_pkg::wr_req_t                    clr_wr_o,
  output absf_pkg::coef_t                      coef_o,
  input  wire logic                            blend_busy_i,
  input  wire absf_pkg::pixel_t                rd_data_i,
  output logic                                 done_o,
  output absf_pkg::pixel_t                     pixel_o,
  input  wire logic                            out_free_i
);
  import absf_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SETUP = 9'b000000010,
    ST_START = 9'b000000100,
    ST_SCAN  = 9'b000001000,
    ST_DRAIN = 9'b000010000,
    ST_READ  = 9'b000100000,
    ST_WAIT  = 9'b001000000,
    ST_CLEAR = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e            state_d, state_q;
  item_t             item_d, item_q;
  coef_t             coef_d, coef_q;
  pixel_t            pix_d, pix_q;
  logic [XW-1:0]     x0_d, x0_q, x1_d, x1_q, x_d, x_q;
  logic [YW-1:0]     y0_d, y0_q, y1_d, y1_q, y_d, y_q;
  logic [ADDR_W-1:0] addr_d, addr_q, row_d, row_q;

  // Clipping terms, valid in SETUP
  logic [EXT_W-1:0]   w_ext, h_ext, cx_ext, cy_ext, r_ext;
  logic [EXT_W-1:0]   lo_x, lo_y, hi_x, hi_y, clip_x, clip_y;
  logic               draw_empty, rd_inside;
  logic [ALPHA_W-1:0] a_sat;
  logic [ADDR_W-1:0]  start_addr;

  always_comb begin
    w_ext  = (EXT_W'(act_width_i) > EXT_W'(MAX_WIDTH)) ? EXT_W'(MAX_WIDTH)
                                                      : EXT_W'(act_width_i);
    h_ext  = (EXT_W'(act_height_i) > EXT_W'(MAX_HEIGHT)) ? EXT_W'(MAX_HEIGHT)
                                                        : EXT_W'(act_height_i);
    cx_ext = EXT_W'(item_q.cx);
    cy_ext = EXT_W'(item_q.cy);
    r_ext  = EXT_W'(item_q.radius);
    lo_x   = (r_ext > cx_ext) ? '0 : cx_ext - r_ext;
    lo_y   = (r_ext > cy_ext) ? '0 : cy_ext - r_ext;
    hi_x   = cx_ext + r_ext;
    hi_y   = cy_ext + r_ext;
    clip_x = (hi_x > w_ext - EXT_W'(1)) ? w_ext - EXT_W'(1) : hi_x;
    clip_y = (hi_y > h_ext - EXT_W'(1)) ? h_ext - EXT_W'(1) : hi_y;
    draw_empty = (w_ext == '0) || (h_ext == '0) || (lo_x >= w_ext) || (lo_y >= h_ext);
    rd_inside  = (cx_ext < w_ext) && (cy_ext < h_ext);
    a_sat = (item_q.alpha > ALPHA_W'(ALPHA_FULL)) ? ALPHA_W'(ALPHA_FULL) : item_q.alpha;
    start_addr = ADDR_W'(ADDR_W'(y0_q) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(x0_q);
  end

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    coef_d   = coef_q;
    pix_d    = pix_q;
    x0_d     = x0_q;
    x1_d     = x1_q;
    y0_d     = y0_q;
    y1_d     = y1_q;
    x_d      = x_q;
    y_d      = y_q;
    addr_d   = addr_q;
    row_d    = row_q;
    rd_o     = '0;
    clr_wr_o = '0;
    done_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = item_i;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        pix_d      = '0;
        coef_d.inv = ALPHA_W'(ALPHA_FULL) - a_sat;
        for (int c = 0; c < NUM_CH; c++) begin
          coef_d.scaled[c] = ACC_W'(item_q.color[c]) * ACC_W'(a_sat);
        end
        unique case (item_q.op)
          OP_CLEAR: begin
            addr_d  = '0;
            state_d = ST_CLEAR;
          end
          OP_DRAW: begin
            x0_d    = lo_x[XW-1:0];
            y0_d    = lo_y[YW-1:0];
            x1_d    = clip_x[XW-1:0];
            y1_d    = clip_y[YW-1:0];
            state_d = draw_empty ? ST_DONE : ST_START;
          end
          OP_READ: begin
            x0_d    = cx_ext[XW-1:0];
            y0_d    = cy_ext[YW-1:0];
            state_d = rd_inside ? ST_START : ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_START: begin
        addr_d  = start_addr;
        row_d   = start_addr;
        x_d     = x0_q;
        y_d     = y0_q;
        state_d = (item_q.op == OP_READ) ? ST_READ : ST_SCAN;
      end
      ST_SCAN: begin
        rd_o.en   = 1'b1;
        rd_o.mix  = 1'b1;
        rd_o.addr = addr_q;
        if (x_q == x1_q) begin
          if (y_q == y1_q) begin
            state_d = ST_DRAIN;
          end else begin
            y_d    = y_q + YW'(1);
            x_d    = x0_q;
            row_d  = row_q + ADDR_W'(MAX_WIDTH);
            addr_d = row_q + ADDR_W'(MAX_WIDTH);
          end
        end else begin
          x_d    = x_q + XW'(1);
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!blend_busy_i) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        rd_o.en   = 1'b1;
        rd_o.addr = addr_q;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        pix_d   = rd_data_i;
        state_d = ST_DONE;
      end
      ST_CLEAR: begin
        clr_wr_o.en   = 1'b1;
        clr_wr_o.addr = addr_q;
        if (addr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_DONE;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end
      ST_DONE: begin
        done_o = 1'b1;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    coef_q <= coef_d;
    pix_q  <= pix_d;
    x0_q   <= x0_d;
    x1_q   <= x1_d;
    y0_q   <= y0_d;
    y1_q   <= y1_d;
    x_q    <= x_d;
    y_q    <= y_d;
    addr_q <= addr_d;
    row_q  <= row_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign coef_o     = coef_q;
  assign pixel_o    = pix_q;

endmodule
`default_nettype wire

// ===== hdl/alpha_blended_square_fill.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// alpha_blended_square_fill: RGB frame store with clear, blended square, read
// Takes one operation per input beat and returns exactly one result beat.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation per beat:
//   clear to black, blend a colored square of side 2r+1 around (x,y) clipped
//   to the active surface, or read one pixel. Output channel (out_valid_o /
//   out_stall_i) returns one beat per operation: the pixel for an on-surface
//   read, zero for everything else.
//   An off-surface read, empty draw or unused code goes straight to its
//   result; an on-surface read issues one store read and takes its data;
//   a draw walks its clipped pixels one per cycle through the read port,
//   then drains the blend pipeline; a clear writes every store address.
//   One item is in work at a time; the input is stalled until the result
//   moves into the output register and opens as that result becomes valid.
//   Reset clears control state and sets the active surface to full size;
//   the frame store contents are undefined until a clear or draw writes them.
//   A stalled result holds in the output register; a finished item behind it
//   waits in the sequencer until the register frees.
//   Write active_width / active_height only while the block is idle.
// -----------------------------------------------------------------------------
module alpha_blended_square_fill (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration
  input  wire logic                                 cfg_we_i,
  input  wire logic [absf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [absf_pkg::CFG_W-1:0]           cfg_data_i,
  // Input channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [absf_pkg::OP_W-1:0]            operation_i,
  input  wire logic [absf_pkg::COORD_W-1:0]         center_x_i,
  input  wire logic [absf_pkg::COORD_W-1:0]         center_y_i,
  input  wire logic [absf_pkg::COORD_W-1:0]         radius_i,
  input  wire logic [absf_pkg::CH_W-1:0]            red_i,
  input  wire logic [absf_pkg::CH_W-1:0]            green_i,
  input  wire logic [absf_pkg::CH_W-1:0]            blue_i,
  input  wire logic [absf_pkg::ALPHA_W-1:0]         alpha_i,
  // Output channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [absf_pkg::CH_W-1:0]                 pixel_red_o,
  output logic [absf_pkg::CH_W-1:0]                 pixel_green_o,
  output logic [absf_pkg::CH_W-1:0]                 pixel_blue_o
);
  import absf_pkg::*;

  logic [CFG_W-1:0] act_width_q, act_height_q;
  logic             out_valid_d, out_valid_q;
  pixel_t           out_pix_d, out_pix_q;
  logic             out_free;

  item_t   item;
  rd_req_t rd_req;
  wr_req_t clr_wr, blend_wr, mem_wr;
  coef_t   coef;
  pixel_t  rd_data, done_pix;
  logic    blend_busy, done;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_width_q  <= ACT_WIDTH_RST;
      act_height_q <= ACT_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ACTIVE_WIDTH:  act_width_q  <= cfg_data_i;
        CFG_ACTIVE_HEIGHT: act_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Gather the input beat
  always_comb begin
    item.op       = operation_i;
    item.cx       = center_x_i;
    item.cy       = center_y_i;
    item.radius   = radius_i;
    item.color[2] = red_i;
    item.color[1] = green_i;
    item.color[0] = blue_i;
    item.alpha    = alpha_i;
  end

  absf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (item),
    .act_width_i  (act_width_q),
    .act_height_i (act_height_q),
    .rd_o         (rd_req),
    .clr_wr_o     (clr_wr),
    .coef_o       (coef),
    .blend_busy_i (blend_busy),
    .rd_data_i    (rd_data),
    .done_o       (done),
    .pixel_o      (done_pix),
    .out_free_i   (out_free)
  );

  absf_blend u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rd_req),
    .rd_data_i (rd_data),
    .coef_i    (coef),
    .wr_o      (blend_wr),
    .busy_o    (blend_busy)
  );

  // Clear sweep and blend write-back never run together; pick the active one
  assign mem_wr = clr_wr.en ? clr_wr : blend_wr;

  absf_frame_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (mem_wr),
    .rd_i      (rd_req),
    .rd_data_o (rd_data)
  );

  // Output register: load when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_pix_d   = out_pix_q;
    if (done && out_free) begin
      out_valid_d = 1'b1;
      out_pix_d   = done_pix;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_pix_q <= out_pix_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_red_o   = out_pix_q[2];
  assign pixel_green_o = out_pix_q[1];
  assign pixel_blue_o  = out_pix_q[0];

  // Assertions
  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_wr.en && blend_wr.en))
    else $error("clear sweep and blend write-back collide");

  a_blend_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blend_busy |-> in_stall_o)
    else $error("blend pipeline active while input is open");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !done))
    else $error("accepted item did not start work");

  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && !out_free) |=> done)
    else $error("finished result dropped while output is full");

endmodule
`default_nettype wire

// ===== bench/tb_alpha_blended_square_fill.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_alpha_blended_square_fill: self-checking bench for the blended square fill
// Feeds clears, blended square draws, pixel reads and the spare operation code
// through a valid/stall driver, mirrors the frame store in a local predictor
// and checks every result beat against the oldest predicted pixel.
// -----------------------------------------------------------------------------
module tb_alpha_blended_square_fill;
  import absf_pkg::*;

  // Operation code three does nothing and answers zero
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef struct {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] radius;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
    logic [ALPHA_W-1:0] alpha;
  } surf_op_t;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // Block inputs, all known from time zero
  logic               cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic [OP_W-1:0]    operation = '0;
  logic [COORD_W-1:0] center_x  = '0;
  logic [COORD_W-1:0] center_y  = '0;
  logic [COORD_W-1:0] radius    = '0;
  logic [CH_W-1:0]    red       = '0;
  logic [CH_W-1:0]    green     = '0;
  logic [CH_W-1:0]    blue      = '0;
  logic [ALPHA_W-1:0] alpha     = '0;
  logic               out_stall = 1'b0;

  // Block outputs
  logic               in_stall_o;
  logic               out_valid_o;
  logic [CH_W-1:0]    pixel_red_o;
  logic [CH_W-1:0]    pixel_green_o;
  logic [CH_W-1:0]    pixel_blue_o;

  alpha_blended_square_fill dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation),
    .center_x_i    (center_x),
    .center_y_i    (center_y),
    .radius_i      (radius),
    .red_i         (red),
    .green_i       (green),
    .blue_i        (blue),
    .alpha_i       (alpha),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .pixel_red_o   (pixel_red_o),
    .pixel_green_o (pixel_green_o),
    .pixel_blue_o  (pixel_blue_o)
  );

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  surf_op_t    pending_q[$];     // operations waiting to go out on the input
  pixel_t      pixel_due_q[$];   // predicted result pixels, oldest first
  pixel_t      frame_model [DEPTH];
  logic [CFG_W-1:0] surf_w = ACT_WIDTH_RST;
  logic [CFG_W-1:0] surf_h = ACT_HEIGHT_RST;
  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned cycle_count    = 0;
  bit          steady = 1'b0;   // no idling on either side while set
  int unsigned last_cx = 0;
  int unsigned last_cy = 0;

  // ---------------------------------------------------------------------------
  // Frame store predictor: apply one operation, return the pixel it answers
  // ---------------------------------------------------------------------------
  function automatic pixel_t blend_frame_step(input surf_op_t it);
    int unsigned w, h, a, inv, x0, y0, x1, y1, idx;
    pixel_t result, old_px, new_px, paint;
    result = '0;
    // Sizes above the store fold back to the store size
    w = (surf_w > MAX_WIDTH) ? MAX_WIDTH : surf_w;
    h = (surf_h > MAX_HEIGHT) ? MAX_HEIGHT : surf_h;
    case (it.op)
      OP_CLEAR: begin
        // Clear blackens the whole store, active surface or not
        for (int i = 0; i < DEPTH; i++) frame_model[i] = '0;
      end
      OP_DRAW: begin
        a = (it.alpha > ALPHA_FULL) ? ALPHA_FULL : it.alpha;
        inv = ALPHA_FULL - a;
        paint = {it.red, it.green, it.blue};
        x0 = (it.radius > it.cx) ? 0 : it.cx - it.radius;
        y0 = (it.radius > it.cy) ? 0 : it.cy - it.radius;
        x1 = it.cx + it.radius;
        y1 = it.cy + it.radius;
        // Empty surface or a square wholly off it leaves the store alone
        if (w != 0 && h != 0 && x0 < w && y0 < h) begin
          if (x1 > w - 1) x1 = w - 1;
          if (y1 > h - 1) y1 = h - 1;
          for (int unsigned y = y0; y <= y1; y++) begin
            for (int unsigned x = x0; x <= x1; x++) begin
              idx = y * MAX_WIDTH + x;
              old_px = frame_model[idx];
              for (int c = 0; c < NUM_CH; c++) begin
                new_px[c] = CH_W'((old_px[c] * inv + paint[c] * a) / ALPHA_FULL);
              end
              frame_model[idx] = new_px;
            end
          end
        end
      end
      OP_READ: begin
        if (it.cx < w && it.cy < h) result = frame_model[it.cy * MAX_WIDTH + it.cx];
      end
      default: ;
    endcase
    return result;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one operation per beat from pending_q, random gaps
  // ---------------------------------------------------------------------------
  surf_op_t offered;

  always @(posedge clk_i or negedge rst_ni) begin
    logic slot_free;
    logic next_valid;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      slot_free = !in_valid;
      // Predict at the accepting edge so the order matches the block's
      if (in_valid && !in_stall_o) begin
        pixel_due_q.push_back(blend_frame_step(offered));
        slot_free = 1'b1;
      end
      next_valid = in_valid;
      if (slot_free) begin
        next_valid = 1'b0;
        if (pending_q.size() != 0 && (steady || $urandom_range(99) >= 21)) begin
          offered = pending_q.pop_front();
          operation <= offered.op;
          center_x  <= offered.cx;
          center_y  <= offered.cy;
          radius    <= offered.radius;
          red       <= offered.red;
          green     <= offered.green;
          blue      <= offered.blue;
          alpha     <= offered.alpha;
          next_valid = 1'b1;
        end
      end
      // Hold valid and payload while stalled
      in_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result beat, stall at random, hold off once for long
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t due;
    logic   next_stall;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (pixel_due_q.size() == 0) begin
          $error("result beat with no pixel predicted: r %0d g %0d b %0d",
                 pixel_red_o, pixel_green_o, pixel_blue_o);
          mismatch_count++;
        end else begin
          due = pixel_due_q.pop_front();
          if (pixel_red_o !== due[2]) begin
            $error("pixel_red expected %0d actual %0d", due[2], pixel_red_o);
            mismatch_count++;
          end
          if (pixel_green_o !== due[1]) begin
            $error("pixel_green expected %0d actual %0d", due[1], pixel_green_o);
            mismatch_count++;
          end
          if (pixel_blue_o !== due[0]) begin
            $error("pixel_blue expected %0d actual %0d", due[0], pixel_blue_o);
            mismatch_count++;
          end
        end
      end
      // Back up the block once while the driver keeps offering beats
      if (!hold_done && results_seen == 150) begin
        hold_left = 500;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (steady) begin
        next_stall = 1'b0;
      end else begin
        next_stall = ($urandom_range(99) < 21);
      end
      out_stall <= next_stall;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_alpha_blended_square_fill NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_op(input logic [OP_W-1:0] op, input int unsigned cx,
                          input int unsigned cy, input int unsigned r,
                          input int unsigned cr, input int unsigned cg,
                          input int unsigned cb, input int unsigned a);
    surf_op_t it;
    it.op = op;
    it.cx = COORD_W'(cx);
    it.cy = COORD_W'(cy);
    it.radius = COORD_W'(r);
    it.red = CH_W'(cr);
    it.green = CH_W'(cg);
    it.blue = CH_W'(cb);
    it.alpha = ALPHA_W'(a);
    pending_q.push_back(it);
  endtask

  // Wait until every beat is out and answered, then let the block settle
  task automatic wait_block_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid || pixel_due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_surface_reg(input cfg_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_ACTIVE_WIDTH) surf_w = val;
    else surf_h = val;
    @(negedge clk_i);
  endtask

  task automatic resize_surface(input int unsigned w, input int unsigned h);
    wait_block_idle();
    write_surface_reg(CFG_ACTIVE_WIDTH, CFG_W'(w));
    write_surface_reg(CFG_ACTIVE_HEIGHT, CFG_W'(h));
  endtask

  // Random operations: mostly draws and reads aimed at the surface, reads
  // often land on the last square so blends get read back
  task automatic queue_random_ops(input int unsigned count, input int unsigned max_r);
    int unsigned w, h, pick, cx, cy, r;
    int          near;
    w = (surf_w > MAX_WIDTH) ? MAX_WIDTH : surf_w;
    h = (surf_h > MAX_HEIGHT) ? MAX_HEIGHT : surf_h;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      cx = (w != 0 && $urandom_range(99) < 85) ? $urandom_range(w - 1) : $urandom_range(255);
      cy = (h != 0 && $urandom_range(99) < 85) ? $urandom_range(h - 1) : $urandom_range(255);
      if (pick < 45) begin
        // Full-range radius only where the clipped square stays cheap
        if (w * h <= 4096 && $urandom_range(99) < 30) r = $urandom_range(255);
        else r = $urandom_range(max_r);
        last_cx = cx;
        last_cy = cy;
        queue_op(OP_DRAW, cx, cy, r, $urandom_range(255), $urandom_range(255),
                 $urandom_range(255), $urandom_range(127));
      end else if (pick < 93) begin
        if ($urandom_range(1) == 1) begin
          near = int'(last_cx) + $urandom_range(2 * max_r + 2) - int'(max_r + 1);
          cx = (near < 0) ? 0 : (near > 255) ? 255 : near;
          near = int'(last_cy) + $urandom_range(2 * max_r + 2) - int'(max_r + 1);
          cy = (near < 0) ? 0 : (near > 255) ? 255 : near;
        end
        queue_op(OP_READ, cx, cy, $urandom_range(255), $urandom_range(255),
                 $urandom_range(255), $urandom_range(255), $urandom_range(127));
      end else begin
        queue_op(OP_SPARE, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(127));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Full surface. Clear first so no read ever sees an unwritten pixel.
    queue_op(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    queue_op(OP_READ, 0, 0, 0, 0, 0, 0, 0);
    queue_op(OP_DRAW, 0, 0, 0, 255, 255, 255, 100);
    queue_op(OP_READ, 0, 0, 0, 0, 0, 0, 0);
    queue_op(OP_DRAW, 0, 0, 0, 0, 0, 0, 0);          // zero alpha keeps the pixel
    queue_op(OP_READ, 0, 0, 0, 0, 0, 0, 0);
    queue_op(OP_DRAW, 255, 255, 3, 12, 200, 77, 127); // alpha saturates, corner clip
    queue_op(OP_READ, 255, 255, 0, 0, 0, 0, 0);
    queue_op(OP_READ, 252, 252, 0, 0, 0, 0, 0);
    queue_op(OP_READ, 251, 251, 0, 0, 0, 0, 0);
    queue_op(OP_DRAW, 128, 64, 2, 255, 0, 128, 50);
    queue_op(OP_DRAW, 128, 64, 1, 1, 2, 3, 37);
    queue_op(OP_READ, 126, 62, 0, 0, 0, 0, 0);
    queue_op(OP_READ, 128, 64, 0, 0, 0, 0, 0);
    queue_op(OP_READ, 130, 66, 0, 0, 0, 0, 0);
    queue_op(OP_SPARE, 255, 255, 255, 255, 255, 255, 127);
    queue_op(OP_DRAW, 0, 255, 255, 90, 180, 45, 1);   // widest square, whole store
    queue_op(OP_READ, 200, 10, 0, 0, 0, 0, 0);

    // Tiny surface: square wholly off, then one clipped to the whole surface
    resize_surface(5, 3);
    queue_op(OP_DRAW, 10, 1, 4, 255, 255, 255, 100);
    queue_op(OP_DRAW, 4, 2, 255, 33, 66, 99, 64);
    queue_op(OP_READ, 4, 2, 0, 0, 0, 0, 0);
    queue_op(OP_READ, 5, 0, 0, 0, 0, 0, 0);
    queue_op(OP_READ, 0, 3, 0, 0, 0, 0, 0);

    // Empty surface: draws do nothing, reads answer zero
    resize_surface(0, 0);
    queue_op(OP_DRAW, 0, 0, 3, 255, 255, 255, 100);
    queue_op(OP_READ, 0, 0, 0, 0, 0, 0, 0);

    // Sizes above the store fold back to the full store
    resize_surface(511, 300);
    queue_op(OP_READ, 255, 255, 0, 0, 0, 0, 0);

    // Random phases over a spread of surface sizes
    resize_surface(256, 256);
    queue_random_ops(600, 4);

    resize_surface(17, 9);
    queue_op(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    queue_random_ops(300, 6);

    resize_surface(256, 256);
    steady = 1'b1;
    queue_random_ops(400, 3);
    wait_block_idle();
    steady = 1'b0;

    resize_surface(1, 256);
    queue_random_ops(200, 5);

    resize_surface(300, 0);
    queue_random_ops(100, 5);

    resize_surface($urandom_range(1, 256), $urandom_range(1, 256));
    queue_op(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    queue_random_ops(250, 4);

    wait_block_idle();
    if (mismatch_count == 0) begin
      $display("tb_alpha_blended_square_fill OK");
    end else begin
      $display("tb_alpha_blended_square_fill NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/absf_pkg.sv
hdl/absf_frame_ram.sv
hdl/absf_blend.sv
hdl/absf_ctrl.sv
hdl/alpha_blended_square_fill.sv
bench/tb_alpha_blended_square_fill.sv
